[rtl/core/status_line_key_value_parser_assert.svh]
// Assertion macros for the status line key/value parser.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef STATUS_LINE_KEY_VALUE_PARSER_ASSERT_SVH
`define STATUS_LINE_KEY_VALUE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLKV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slkv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLKV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slkv assertion failed");

`endif

[rtl/core/slkv_pkg.sv]
// Package for the status line key/value parser: field ids, character
// codes, parser state types and the key lookup. No dependencies.
package slkv_pkg;

    // Field identifiers.
    localparam logic [3:0] FID_S    = 4'd0;
    localparam logic [3:0] FID_W    = 4'd1;
    localparam logic [3:0] FID_P    = 4'd2;
    localparam logic [3:0] FID_H    = 4'd3;
    localparam logic [3:0] FID_HT   = 4'd4;
    localparam logic [3:0] FID_HTT  = 4'd5;
    localparam logic [3:0] FID_B    = 4'd6;
    localparam logic [3:0] FID_BT   = 4'd7;
    localparam logic [3:0] FID_C    = 4'd8;
    localparam logic [3:0] FID_CT   = 4'd9;
    localparam logic [3:0] FID_PR   = 4'd10;
    localparam logic [3:0] FID_TR   = 4'd11;
    localparam logic [3:0] FID_NONE = 4'd15;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_W     = 8'h57;

    // Where the line parse stands.
    typedef enum logic [2:0] {
        PH_KEY   = 3'b001,
        PH_VALUE = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    // Where the decimal value decode stands.
    typedef enum logic [2:0] {
        VS_SPACE  = 3'b001,
        VS_DIGITS = 3'b010,
        VS_STOP   = 3'b100
    } vstage_t;

    // Maps a key of one to three characters to its field id.
    function automatic logic [3:0] lookup_key(input logic [23:0] text,
                                              input logic [2:0]  len);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [3:0] id;
        a  = text[7:0];
        b  = text[15:8];
        c  = text[23:16];
        id = FID_NONE;
        if (len == 3'd3)
        begin
            if (a == CH_H && b == CH_T && c == CH_T) id = FID_HTT;
        end
        else if (len == 3'd2)
        begin
            if      (a == CH_H && b == CH_T) id = FID_HT;
            else if (a == CH_B && b == CH_T) id = FID_BT;
            else if (a == CH_C && b == CH_T) id = FID_CT;
            else if (a == CH_P && b == CH_R) id = FID_PR;
            else if (a == CH_T && b == CH_R) id = FID_TR;
        end
        else if (len == 3'd1)
        begin
            if      (a == CH_S) id = FID_S;
            else if (a == CH_W) id = FID_W;
            else if (a == CH_P) id = FID_P;
            else if (a == CH_H) id = FID_H;
            else if (a == CH_B) id = FID_B;
            else if (a == CH_C) id = FID_C;
        end
        return id;
    endfunction

endpackage

[rtl/core/status_line_key_value_parser.sv]
// Status line key/value parser: byte-wide request in, field update out.
// Depends on slkv_pkg and status_line_key_value_parser_assert.svh.
//
// Usage:
// Bytes of a serial status stream arrive as requests on the byte channel
// (byte_valid, byte_ready, rx_byte). Lines end in a newline and hold
// pipe-separated KEY:VALUE pairs; carriage returns are dropped and a line
// keeps at most LINE_LIMIT-1 bytes. When a value of a known key ends, at
// a pipe, a newline or a zero byte, one update leaves on the update
// channel (update_valid, update_ready, field_id, field_value).
// Latency: an update is presented in the cycle after the byte that ends
// the value is accepted. Throughput: one byte per cycle unless stalled;
// the parser state is a single register stage, one short step per byte.
// The update sits in an output register; a new byte is taken whenever
// that register is empty or is being emptied in the same cycle, so a
// stalled receiver holds back the byte channel only while an update waits.
// Reset clears all line state and empties the output register.
// Values wrap modulo 2^32; W, P and H report 0 or 1.
module status_line_key_value_parser
    import slkv_pkg::*;
#(
    parameter int LINE_LIMIT = 384
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         rx_byte,
    output logic               update_valid,
    input  logic               update_ready,
    output logic [3:0]         field_id,
    output logic signed [31:0] field_value
);

    `include "status_line_key_value_parser_assert.svh"

    localparam int CNT_W = (LINE_LIMIT > 2) ? $clog2(LINE_LIMIT) : 1;
    localparam logic [CNT_W-1:0] LINE_FULL = CNT_W'(LINE_LIMIT - 1);

    // Parser state.
    logic [CNT_W-1:0] line_count_reg, line_count_next;
    phase_t           phase_reg, phase_next;
    logic [23:0]      key_text_reg, key_text_next;
    logic [2:0]       key_len_reg, key_len_next;
    logic [3:0]       match_reg, match_next;
    vstage_t          vstage_reg, vstage_next;
    logic             neg_reg, neg_next;
    logic [31:0]      accum_reg, accum_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       out_id_reg, out_id_next;
    logic [31:0]      out_value_reg, out_value_next;

    logic             accept;
    logic             emit;
    logic             is_digit;
    logic             is_space;
    logic [31:0]      signed_value;
    logic [31:0]      emit_value;

    assign byte_ready   = !out_valid_reg || update_ready;
    assign accept       = byte_valid && byte_ready;
    assign update_valid = out_valid_reg;
    assign field_id     = out_id_reg;
    assign field_value  = out_value_reg;

    // Character classes and the value an update would carry now.
    always_comb
    begin
        is_digit     = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        is_space     = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB)
                    || (rx_byte == CH_VT) || (rx_byte == CH_FF);
        signed_value = neg_reg ? (32'd0 - accum_reg) : accum_reg;
        if (match_reg == FID_W || match_reg == FID_P || match_reg == FID_H)
        begin
            emit_value = {31'd0, (signed_value != 32'd0)};
        end
        else
        begin
            emit_value = signed_value;
        end
    end

    // One parse step per accepted byte.
    always_comb
    begin
        line_count_next = line_count_reg;
        phase_next      = phase_reg;
        key_text_next   = key_text_reg;
        key_len_next    = key_len_reg;
        match_next      = match_reg;
        vstage_next     = vstage_reg;
        neg_next        = neg_reg;
        accum_next      = accum_reg;
        emit            = 1'b0;

        if (accept)
        begin
            if (rx_byte == CH_LF)
            begin
                // End of line: flush an open value and start afresh.
                emit            = (phase_reg == PH_VALUE) && (match_reg != FID_NONE);
                line_count_next = '0;
                phase_next      = PH_KEY;
                key_text_next   = '0;
                key_len_next    = '0;
                match_next      = FID_NONE;
                vstage_next     = VS_SPACE;
                neg_next        = 1'b0;
                accum_next      = '0;
            end
            else if (line_count_reg != LINE_FULL && rx_byte != CH_CR)
            begin
                line_count_next = line_count_reg + 1'b1;
                unique case (phase_reg)
                    PH_DONE:
                    begin
                    end
                    PH_KEY:
                    begin
                        if (rx_byte == CH_NUL)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (rx_byte == CH_COLON)
                        begin
                            match_next  = lookup_key(key_text_reg, key_len_reg);
                            vstage_next = VS_SPACE;
                            neg_next    = 1'b0;
                            accum_next  = '0;
                            phase_next  = PH_VALUE;
                        end
                        else
                        begin
                            unique case (key_len_reg)
                                3'd0:    key_text_next[7:0]   = rx_byte;
                                3'd1:    key_text_next[15:8]  = rx_byte;
                                3'd2:    key_text_next[23:16] = rx_byte;
                                default: key_text_next        = key_text_reg;
                            endcase
                            if (key_len_reg < 3'd4) key_len_next = key_len_reg + 3'd1;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (rx_byte == CH_NUL)
                        begin
                            emit       = (match_reg != FID_NONE);
                            phase_next = PH_DONE;
                        end
                        else if (rx_byte == CH_PIPE)
                        begin
                            emit          = (match_reg != FID_NONE);
                            key_text_next = '0;
                            key_len_next  = '0;
                            match_next    = FID_NONE;
                            vstage_next   = VS_SPACE;
                            neg_next      = 1'b0;
                            accum_next    = '0;
                            phase_next    = PH_KEY;
                        end
                        else if (vstage_reg != VS_STOP)
                        begin
                            // Decimal decode: times ten as two shifts and an add.
                            if (is_digit)
                            begin
                                accum_next  = (accum_reg << 3) + (accum_reg << 1)
                                            + {28'd0, rx_byte[3:0]};
                                vstage_next = VS_DIGITS;
                            end
                            else if (vstage_reg == VS_SPACE && is_space)
                            begin
                                vstage_next = VS_SPACE;
                            end
                            else if (vstage_reg == VS_SPACE
                                     && (rx_byte == CH_MINUS || rx_byte == CH_PLUS))
                            begin
                                neg_next    = (rx_byte == CH_MINUS);
                                vstage_next = VS_DIGITS;
                            end
                            else
                            begin
                                vstage_next = VS_STOP;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_KEY;
                    end
                endcase
            end
        end
    end

    // Output register loads on an update and empties when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !update_ready;
        out_id_next    = out_id_reg;
        out_value_next = out_value_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_id_next    = match_reg;
            out_value_next = emit_value;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            phase_reg      <= PH_KEY;
            key_len_reg    <= '0;
            match_reg      <= FID_NONE;
            vstage_reg     <= VS_SPACE;
            neg_reg        <= 1'b0;
            key_text_reg   <= '0;
            accum_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            phase_reg      <= phase_next;
            key_len_reg    <= key_len_next;
            match_reg      <= match_next;
            vstage_reg     <= vstage_next;
            neg_reg        <= neg_next;
            key_text_reg   <= key_text_next;
            accum_reg      <= accum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Update payload.
    always_ff @(posedge clk)
    begin
        out_id_reg    <= out_id_next;
        out_value_reg <= out_value_next;
    end

    // Checks on the parser's own behaviour.
    `SLKV_ASSERT_SAME(a_known_field, update_valid, field_id <= FID_TR)
    `SLKV_ASSERT_SAME(a_flag_bool, update_valid && (field_id == FID_W || field_id == FID_P || field_id == FID_H), field_value == 32'sd0 || field_value == 32'sd1)
    `SLKV_ASSERT_NEXT(a_newline_resets, accept && rx_byte == CH_LF, phase_reg == PH_KEY && line_count_reg == '0 && match_reg == FID_NONE)
    `SLKV_ASSERT_SAME(a_count_bound, 1'b1, line_count_reg <= LINE_FULL)
    `SLKV_ASSERT_NEXT(a_no_update_in_key, accept && phase_reg == PH_KEY && rx_byte != CH_LF && !update_ready, update_valid == $past(update_valid))

endmodule

[tb/status_line_key_value_parser_tb.sv]
`timescale 1ns / 1ps
// Testbench for status_line_key_value_parser: streams bytes of random status lines
// and checks each field update against a cycle-free parser written here.
// Depends on slkv_pkg and the parser RTL.
module status_line_key_value_parser_tb;
    import slkv_pkg::*;

    localparam int LINE_LIMIT  = 384;
    localparam int BYTE_TARGET = 1450;
    localparam int PHASE_BYTES = 480;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;

    // One byte request with the idling profile it is sent under.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] pace;
        logic       drain;
    } rx_req_t;

    // One field update as the parser should report it.
    typedef struct packed {
        logic [3:0]  id;
        logic [31:0] value;
    } field_upd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    logic [7:0]         rx_byte = 8'd0;
    logic               update_valid;
    logic               update_ready = 1'b0;
    logic [3:0]         field_id;
    logic signed [31:0] field_value;

    rx_req_t    rx_requests[$];
    field_upd_t pending_updates[$];
    int         send_idle_pct [3] = '{18, 77, 0};
    int         recv_idle_pct [3] = '{77, 18, 0};
    logic [1:0] pace = 2'd0;
    logic       byte_fire = 1'b0;
    int         quiet_cycles = 0;
    int         error_count = 0;
    int         gen_count = 0;

    string known_keys [12] = '{"S", "W", "P", "H", "HT", "HTT", "B", "BT", "C", "CT",
                               "PR", "TR"};
    string odd_keys [8] = '{"G", "X", "HTTX", "H|T", "BTT", "T", "pr", ""};
    logic [7:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

    // Line parser state mirrored from the block.
    logic [8:0]  line_len;
    phase_t      line_phase;
    logic [23:0] key_chars;
    logic [2:0]  key_len;
    logic [3:0]  value_field;
    vstage_t     digit_stage;
    logic        value_neg;
    logic [31:0] value_mag;

    status_line_key_value_parser #(
        .LINE_LIMIT(LINE_LIMIT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .rx_byte     (rx_byte),
        .update_valid(update_valid),
        .update_ready(update_ready),
        .field_id    (field_id),
        .field_value (field_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Forgets the current key and value.
    function automatic void clear_pair();
        key_chars   = 24'd0;
        key_len     = 3'd0;
        value_field = FID_NONE;
        digit_stage = VS_SPACE;
        value_neg   = 1'b0;
        value_mag   = 32'd0;
    endfunction

    // Returns the parser to the start of a line.
    function automatic void reset_line();
        line_len   = 9'd0;
        line_phase = PH_KEY;
        clear_pair();
    endfunction

    // Field id of the collected key; only exact keys of one to three characters match.
    function automatic logic [3:0] field_of_key();
        logic [3:0] id;
        id = FID_NONE;
        if (key_len == 3'd3)
        begin
            if (key_chars == {CH_T, CH_T, CH_H}) id = FID_HTT;
        end
        else if (key_len == 3'd2)
        begin
            case (key_chars[15:0])
                {CH_T, CH_H}: id = FID_HT;
                {CH_T, CH_B}: id = FID_BT;
                {CH_T, CH_C}: id = FID_CT;
                {CH_R, CH_P}: id = FID_PR;
                {CH_R, CH_T}: id = FID_TR;
                default:      id = FID_NONE;
            endcase
        end
        else if (key_len == 3'd1)
        begin
            case (key_chars[7:0])
                CH_S:    id = FID_S;
                CH_W:    id = FID_W;
                CH_P:    id = FID_P;
                CH_H:    id = FID_H;
                CH_B:    id = FID_B;
                CH_C:    id = FID_C;
                default: id = FID_NONE;
            endcase
        end
        return id;
    endfunction

    // Builds the update for the value that has just ended, if its key is known.
    function automatic bit close_value(output field_upd_t upd);
        logic [31:0] v;
        bit          hit;
        upd = '0;
        hit = 1'b0;
        if (value_field != FID_NONE)
        begin
            v = value_neg ? -value_mag : value_mag;
            if (value_field == FID_W || value_field == FID_P || value_field == FID_H)
                v = (v != 32'd0) ? 32'd1 : 32'd0;
            upd.id    = value_field;
            upd.value = v;
            hit       = 1'b1;
        end
        return hit;
    endfunction

    // Decimal decode of one value character: blanks, then a sign, then digits.
    function automatic void take_value_char(input logic [7:0] c);
        if (digit_stage != VS_STOP)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                value_mag   = value_mag * 32'd10 + 32'(c - CH_ZERO);
                digit_stage = VS_DIGITS;
            end
            else if (digit_stage == VS_SPACE && (c == CH_MINUS || c == CH_PLUS))
            begin
                value_neg   = (c == CH_MINUS);
                digit_stage = VS_DIGITS;
            end
            else if (!(digit_stage == VS_SPACE &&
                       (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)))
                digit_stage = VS_STOP;
        end
    endfunction

    // Advances the parser by one accepted byte; returns 1 when an update results.
    function automatic bit parse_byte(input logic [7:0] c, output field_upd_t upd);
        bit hit;
        hit = 1'b0;
        upd = '0;
        if (c == CH_LF)
        begin
            if (line_phase == PH_VALUE) hit = close_value(upd);
            reset_line();
        end
        else if (line_len < LINE_LIMIT - 1 && c != CH_CR)
        begin
            line_len = line_len + 9'd1;
            if (line_phase != PH_DONE)
            begin
                if (c == CH_NUL)
                begin
                    // A zero byte ends the parse of the rest of the line.
                    if (line_phase == PH_VALUE) hit = close_value(upd);
                    line_phase = PH_DONE;
                end
                else if (line_phase == PH_KEY)
                begin
                    if (c == CH_COLON)
                    begin
                        value_field = field_of_key();
                        digit_stage = VS_SPACE;
                        value_neg   = 1'b0;
                        value_mag   = 32'd0;
                        line_phase  = PH_VALUE;
                    end
                    else
                    begin
                        if (key_len < 3'd3) key_chars[8 * key_len +: 8] = c;
                        if (key_len < 3'd4) key_len = key_len + 3'd1;
                    end
                end
                else if (c == CH_PIPE)
                begin
                    hit = close_value(upd);
                    clear_pair();
                    line_phase = PH_KEY;
                end
                else
                    take_value_char(c);
            end
        end
        return hit;
    endfunction

    // Queues one byte request; the byte position picks the idling profile and the
    // first byte of each later profile waits for all outstanding updates.
    task automatic push_char(input logic [7:0] c);
        rx_req_t req;
        req.data  = c;
        req.pace  = (gen_count < PHASE_BYTES) ? 2'd0 :
                    (gen_count < 2 * PHASE_BYTES) ? 2'd1 : 2'd2;
        req.drain = (gen_count == PHASE_BYTES || gen_count == 2 * PHASE_BYTES);
        rx_requests.push_back(req);
        gen_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // A value with random blanks, sign, digit count and trailing junk.
    task automatic push_value();
        int r;
        int n;
        repeat ($urandom_range(0, 2)) push_char(blanks[$urandom_range(3)]);
        r = $urandom_range(5);
        if (r == 0) push_char(CH_MINUS);
        else if (r == 1) push_char(CH_PLUS);
        n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
        repeat (n)
        begin
            push_char(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(15) == 0) push_char(CH_CR);
        end
        r = $urandom_range(11);
        if (r == 0) push_char(CH_SPACE);
        else if (r == 1) push_char(CH_MINUS);
        else if (r == 2) push_char(CH_COLON);
    endtask

    // Stimulus, reset and the end of the run.
    initial
    begin : stimulus
        int  kind;
        int  pairs;
        int  tail;
        bit  long_done;
        long_done = 1'b0;
        reset_line();

        // Directed lines: most negative value after a vertical tab, carriage return
        // before newline, a zero byte that closes a value and hides the rest.
        push_text("HT:");
        push_char(CH_VT);
        push_text("-2147483648|W:0");
        push_char(CH_CR);
        push_char(CH_LF);
        push_text("C:9");
        push_char(CH_NUL);
        push_text("|P:1");
        push_char(CH_LF);

        while (gen_count < BYTE_TARGET)
        begin
            kind = $urandom_range(99);
            if (!long_done && gen_count > 1000)
            begin
                // A line that runs past the limit; the dropped tail holds a pair.
                long_done = 1'b1;
                push_text("B:");
                repeat (385) push_char(CH_ZERO + 8'($urandom_range(9)));
                push_text("|S:3");
                push_char(CH_CR);
                push_char(CH_LF);
            end
            else if (kind < 78)
            begin
                pairs = $urandom_range(1, 4);
                for (int p = 0; p < pairs; p++)
                begin
                    if (p > 0) push_char(CH_PIPE);
                    if ($urandom_range(9) < 8) push_text(known_keys[$urandom_range(11)]);
                    else push_text(odd_keys[$urandom_range(7)]);
                    push_char(CH_COLON);
                    push_value();
                end
                tail = $urandom_range(19);
                if (tail == 0)
                    push_text("|HT");
                else if (tail == 1)
                begin
                    push_char(CH_NUL);
                    push_text("|S:5");
                end
                else if (tail == 2)
                    push_char(CH_PIPE);
                if ($urandom_range(3) == 0) push_char(CH_CR);
                push_char(CH_LF);
            end
            else if (kind < 96)
            begin
                repeat ($urandom_range(1, 16)) push_char(8'($urandom_range(255)));
                if ($urandom_range(4) != 0) push_char(CH_LF);
            end
            else
                push_char(CH_LF);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (rx_requests.size() > 0 || byte_valid) @(posedge clk);
        while (pending_updates.size() > 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Byte driver: presents the next request at the falling edge once the previous
    // one was taken, honouring the idling profile and any drain point.
    always @(negedge clk)
    begin : driver
        logic    next_valid;
        logic [7:0] next_byte;
        rx_req_t req;
        next_valid = byte_valid;
        next_byte  = rx_byte;
        if (rst_n)
        begin
            if (byte_valid && byte_fire) next_valid = 1'b0;
            if (!next_valid && rx_requests.size() > 0
                && !(rx_requests[0].drain && pending_updates.size() > 0)
                && $urandom_range(99) >= send_idle_pct[rx_requests[0].pace])
            begin
                req        = rx_requests.pop_front();
                next_valid = 1'b1;
                next_byte  = req.data;
                pace      <= req.pace;
            end
        end
        byte_valid <= next_valid;
        rx_byte    <= next_byte;
    end

    // Update receiver: stalls at random under the current profile.
    always @(negedge clk)
    begin
        update_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct[pace]);
    end

    // Monitor: checks each update taken, then predicts from each byte taken.
    always @(posedge clk)
    begin : monitor
        field_upd_t want;
        field_upd_t next_upd;
        byte_fire <= rst_n && byte_valid && byte_ready;
        if (rst_n && update_valid && update_ready)
        begin
            if (pending_updates.size() == 0)
            begin
                $error("unexpected update: field_id %0d field_value %0d",
                       field_id, field_value);
                error_count++;
            end
            else
            begin
                want = pending_updates.pop_front();
                if (field_id !== want.id)
                begin
                    $error("field_id mismatch: expected %0d, got %0d", want.id, field_id);
                    error_count++;
                end
                if (field_value !== want.value)
                begin
                    $error("field_value mismatch: expected %0d, got %0d",
                           $signed(want.value), field_value);
                    error_count++;
                end
            end
        end
        if (rst_n && byte_valid && byte_ready)
        begin
            if (parse_byte(rx_byte, next_upd)) pending_updates.push_back(next_upd);
        end
        if ((byte_valid && byte_ready) || (update_valid && update_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
